// ----- hdl/bst_pkg.sv -----
// Shared types and constants for the bounded set table.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 7;
  localparam int CAP_BITS   = 7;
  localparam int OP_BITS    = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [VALUE_BITS-1:0] value;
  } bst_req_t;

  typedef struct packed {
    logic                  was_present;
    logic                  changed;
    logic                  full_res;
    logic [COUNT_BITS-1:0] count;
  } bst_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_MOVE,
    S_DONE
  } bst_state_t;

endpackage

// ----- hdl/bst_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bounded_set_table.sv -----
// Top level of the bounded set table: request decode, RAM scan and result register.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  bst_req_t  (op, value)
//   rsp       out        rsp_valid / rsp_stall  bst_res_t  (was_present, changed, full_res, count)
//   cfg       in         cfg_we                 capacity, 7 bits
//
// A request scans the held entries, one per cycle through the single read port of the
// element RAM.
// A remove that hits fetches the last entry in S_APPLY before it moves it in S_MOVE.
// Synchronous reset empties the set and restores the capacity; the RAM is not cleared.
// A finished result waits in the output register while the next request is taken;
// that request completes its scan but holds in its last state until the register is free.
`timescale 1ns / 1ps

module bounded_set_table #(
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  bst_pkg::bst_req_t    req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output bst_pkg::bst_res_t    rsp
);

  import bst_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;

  bst_state_t state, state_next;

  logic [CAP_BITS-1:0]   capacity;
  logic [CW-1:0]         count, count_next;
  logic [OP_BITS-1:0]    op_q, op_q_next;
  logic [VALUE_BITS-1:0] value_q, value_q_next;
  logic                  full_q, full_q_next;
  logic                  found, found_next;
  logic                  chg, chg_next;
  logic [AW-1:0]         pos, pos_next;
  logic [CW-1:0]         issue_idx, issue_idx_next;
  logic                  rd_pend, rd_pend_next;
  logic [AW-1:0]         cmp_idx, cmp_idx_next;
  logic                  rsp_valid_next;
  bst_res_t              rsp_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [EW-1:0]         cap_ext;
  logic [EW-1:0]         cap_eff;
  logic [CW-1:0]         last_idx;
  logic                  hit;

  bst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The effective capacity never exceeds the depth of the store.
  assign cap_ext  = EW'(capacity);
  assign cap_eff  = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
  assign last_idx = count - CW'(1);
  assign hit      = rd_pend && (ram_rdata == value_q);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_q_next      = op_q;
    value_q_next   = value_q;
    full_q_next    = full_q;
    found_next     = found;
    chg_next       = chg;
    pos_next       = pos;
    issue_idx_next = issue_idx;
    rd_pend_next   = rd_pend;
    cmp_idx_next   = cmp_idx;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    ram_we         = 1'b0;
    ram_waddr      = pos;
    ram_wdata      = value_q;
    ram_raddr      = issue_idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_q_next      = req.op;
          value_q_next   = req.value;
          full_q_next    = (EW'(count) >= cap_eff);
          found_next     = 1'b0;
          chg_next       = 1'b0;
          issue_idx_next = '0;
          rd_pend_next   = 1'b0;
          state_next     = S_SCAN;
        end
      end

      // One read is issued per cycle; the entry read in the previous cycle is compared.
      S_SCAN: begin
        if (hit) begin
          found_next   = 1'b1;
          pos_next     = cmp_idx;
          rd_pend_next = 1'b0;
          state_next   = S_APPLY;
        end else if (issue_idx < count) begin
          rd_pend_next   = 1'b1;
          cmp_idx_next   = issue_idx[AW-1:0];
          issue_idx_next = issue_idx + CW'(1);
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            state_next = S_APPLY;
          end
        end
      end

      S_APPLY: begin
        if (op_q == OP_REMOVE && found) begin
          ram_raddr  = last_idx[AW-1:0];
          state_next = S_MOVE;
        end else if (op_q == OP_ADD && !found && !full_q) begin
          ram_we     = 1'b1;
          ram_waddr  = count[AW-1:0];
          ram_wdata  = value_q;
          count_next = count + CW'(1);
          chg_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end

      // The last held entry fills the hole left by the removed one.
      S_MOVE: begin
        ram_we     = 1'b1;
        ram_waddr  = pos;
        ram_wdata  = ram_rdata;
        count_next = count - CW'(1);
        chg_next   = 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.was_present = found;
          rsp_next.changed     = chg;
          rsp_next.full_res    = full_q;
          rsp_next.count       = COUNT_BITS'(count);
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      capacity  <= CAP_RESET;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      rd_pend   <= rd_pend_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    value_q   <= value_q_next;
    full_q    <= full_q_next;
    found     <= found_next;
    chg       <= chg_next;
    pos       <= pos_next;
    issue_idx <= issue_idx_next;
    cmp_idx   <= cmp_idx_next;
    rsp       <= rsp_next;
  end

endmodule

// ----- hdl/bst_check.sv -----
// Port-level checks for the bounded set table, bound to the top level.
`timescale 1ns / 1ps

module bst_check #(
  parameter int DEPTH = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input bst_pkg::bst_res_t rsp
);

  import bst_pkg::*;

  // A held result must not change while the receiver stalls it.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Once a request is taken the block is busy with it in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    !rst && req_valid && !req_stall |=> req_stall)
    else $error("request port not busy after a request");

  // An insertion only happens below capacity and leaves at least one element.
  a_insert_sane: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.changed && !rsp.was_present |-> !rsp.full_res && (rsp.count != '0))
    else $error("insertion reported when full or with an empty set");

  // The reported count never exceeds the depth of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 127) || (int'(rsp.count) <= DEPTH))
    else $error("count beyond store depth");

endmodule

bind bounded_set_table bst_check #(.DEPTH(DEPTH)) u_bst_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- test/bounded_set_table_tb.sv -----
// Self-checking testbench for the bounded set table against a set predictor.
`timescale 1ns / 1ps

module bounded_set_table_tb;
  import bst_pkg::*;

  localparam int DEPTH = 64;
  localparam int POOL_SIZE = 80;
  localparam int SEGMENT_ITEMS = 150;
  localparam int FILL_ITEMS = 105;
  localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

  // Tracks the set contents and capacity, and holds the results still owed by the block.
  class membership_tracker;
    int slots;
    bit [CAP_BITS-1:0] capacity;
    bit [VALUE_BITS-1:0] members[$];
    bst_res_t owed_results[$];
    int errors;

    function new(int depth);
      slots = depth;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void note_request(bst_req_t item);
      int cap;
      int pos;
      bit present;
      bit full;
      bit altered;
      bst_res_t outcome;
      cap = (capacity > slots) ? slots : capacity;
      pos = -1;
      for (int i = 0; i < members.size(); i++) begin
        if (pos < 0 && members[i] == item.value) pos = i;
      end
      present = (pos >= 0);
      full = (members.size() >= cap);
      altered = 1'b0;
      case (item.op)
        OP_ADD: begin
          if (!present && !full && members.size() < slots) begin
            members.push_back(item.value);
            altered = 1'b1;
          end
        end
        OP_REMOVE: begin
          // The last held entry fills the gap left by the removed one.
          if (present) begin
            members[pos] = members[members.size() - 1];
            void'(members.pop_back());
            altered = 1'b1;
          end
        end
        default: begin
        end
      endcase
      outcome.was_present = present;
      outcome.changed = altered;
      outcome.full_res = full;
      outcome.count = COUNT_BITS'(members.size());
      owed_results.push_back(outcome);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(bst_res_t got);
      bst_res_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with no request outstanding (count %0d)", got.count));
        return;
      end
      want = owed_results.pop_front();
      if (got.was_present !== want.was_present)
        report($sformatf("was_present %b, expected %b", got.was_present, want.was_present));
      if (got.changed !== want.changed)
        report($sformatf("changed %b, expected %b", got.changed, want.changed));
      if (got.full_res !== want.full_res)
        report($sformatf("full_res %b, expected %b", got.full_res, want.full_res));
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_wdata;
  logic req_valid;
  logic req_stall;
  bst_req_t req;
  logic rsp_valid;
  logic rsp_stall;
  bst_res_t rsp;

  membership_tracker tracker;
  int send_idle_pct;
  int stall_pct;
  int add_cursor;
  logic [VALUE_BITS-1:0] value_pool [POOL_SIZE];
  bit [CAP_BITS-1:0] segment_caps [9];

  bounded_set_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_result(rsp);
  end

  // Entered just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic send_request(input logic [OP_BITS-1:0] op, input logic [VALUE_BITS-1:0] value);
    bst_req_t item;
    item.op = op;
    item.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(item);
    @(negedge clk);
  endtask

  // Holds off new requests until every owed result has been returned.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input bit [CAP_BITS-1:0] cap);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.capacity = cap;
  endtask

  task automatic run_segment(input int items);
    int roll;
    int mix;
    logic [VALUE_BITS-1:0] pick;
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(99);
      pick = value_pool[$urandom_range(POOL_SIZE - 1)];
      if (roll < 8) begin
        send_request(OP_BITS'($urandom_range(3)), $urandom);
      end else begin
        // Adds walk through the pool so they mostly hit absent values and the set fills.
        mix = $urandom_range(99);
        if (i < FILL_ITEMS ? mix < 75 : mix < 15) begin
          send_request(OP_ADD, value_pool[add_cursor]);
          add_cursor = (add_cursor + 1) % POOL_SIZE;
        end else if (i < FILL_ITEMS ? mix < 88 : mix < 80) begin
          send_request(OP_REMOVE, pick);
        end else if (mix < 96) begin
          send_request(OP_QUERY, pick);
        end else begin
          send_request(OP_SPARE, pick);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    add_cursor = 0;
    tracker = new(DEPTH);
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    segment_caps = '{7'd64, 7'd127, 7'd3, 7'd0, 7'd64, 7'd1, 7'd65, 7'd20, 7'd63};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 32;
    stall_pct = 71;
    // Empty set, extreme values, duplicates, absent removes and the unused operation code.
    send_request(OP_QUERY, '0);
    send_request(OP_REMOVE, '0);
    send_request(OP_ADD, '0);
    send_request(OP_ADD, '1);
    send_request(OP_ADD, '0);
    send_request(OP_QUERY, '1);
    send_request(OP_SPARE, '0);
    send_request(OP_REMOVE, '1);
    send_request(OP_REMOVE, '1);
    send_request(OP_ADD, 32'h5555_5555);
    send_request(OP_ADD, 32'hAAAA_AAAA);
    send_request(OP_ADD, 32'h1234_5678);
    // Capacity lowered below the number held: adds refuse, removes still work.
    write_capacity(7'd2);
    send_request(OP_ADD, 32'h0000_0001);
    send_request(OP_ADD, '0);
    send_request(OP_REMOVE, 32'h5555_5555);
    send_request(OP_QUERY, 32'h1234_5678);
    send_request(OP_REMOVE, '0);
    send_request(OP_ADD, 32'h0000_0001);
    write_capacity(7'd0);
    send_request(OP_ADD, 32'h0000_0007);
    send_request(OP_QUERY, 32'hAAAA_AAAA);
    // Capacity above the store depth is clipped to the depth.
    write_capacity(7'd127);
    send_request(OP_ADD, 32'h0000_0007);
    send_request(OP_REMOVE, 32'h0000_0007);
    send_request(OP_REMOVE, 32'h1234_5678);

    for (int profile = 0; profile < 3; profile++) begin
      case (profile)
        0: begin
          send_idle_pct = 32;
          stall_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          stall_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        write_capacity(segment_caps[profile * 3 + seg]);
        run_segment(SEGMENT_ITEMS);
      end
    end

    drain_results();
    repeat (DEPTH + 8) @(negedge clk);
    if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
      $display("bounded_set_table_tb: clean");
    end else begin
      $display("bounded_set_table_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("bounded_set_table_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bst_pkg.sv
hdl/bst_ram.sv
hdl/bounded_set_table.sv
hdl/bst_check.sv
test/bounded_set_table_tb.sv
